// ----- sv/soc_coulomb_counter_macros.svh -----
// ----------------------------------------------------------------------------
// Coulomb counter assertion macros
// Clocked implication checks with an active-low reset guard.
// ----------------------------------------------------------------------------
`ifndef SOC_COULOMB_COUNTER_MACROS_SVH
`define SOC_COULOMB_COUNTER_MACROS_SVH

// same-cycle implication
`define SCC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("coulomb counter check failed");

// next-cycle implication
`define SCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("coulomb counter check failed");

`endif

// ----- sv/scc_pkg.sv -----
// ----------------------------------------------------------------------------
// Coulomb counter package
// Widths, constants, register indexes and shared types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package scc_pkg;

  localparam int unsigned MUL_W     = 16;
  localparam int unsigned PROD_W    = 32;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_W);
  localparam int unsigned DVD_W     = 32;
  localparam int unsigned DSR_W     = 22;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned RES_W     = 23;
  localparam int unsigned SUM_W     = 34;
  localparam int unsigned CHG_W     = 18;
  localparam int unsigned DELTA_W   = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EMPTY    = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_SET    = 1'b1;

  localparam logic [CFG_W-1:0] CAPACITY_RST = 16'd1000;
  localparam logic [CFG_W-1:0] FULL_RST     = 16'd4150;
  localparam logic [CFG_W-1:0] EMPTY_RST    = 16'd3000;

  localparam logic [DSR_W-1:0] MS_PER_HOUR = 22'd3600000;
  localparam logic [DSR_W-1:0] PCT_DIV     = 22'd100;
  localparam logic [MUL_W-1:0] PERMILLE    = 16'd1000;
  localparam logic [6:0]       PCT_MAX     = 7'd100;
  localparam logic [10:0]      ROUND_BIAS  = 11'd5;
  localparam logic [7:0]       RECIP_TEN   = 8'd205;
  localparam int unsigned      RECIP_SHIFT = 11;

  typedef struct packed {
    logic busy;
    logic done;
  } scc_unit_status_t;

endpackage

`default_nettype wire

// ----- sv/scc_mul.sv -----
// ----------------------------------------------------------------------------
// Coulomb counter serial multiplier
// Unsigned shift-add multiply, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scc_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [scc_pkg::MUL_W-1:0]    a_i,
  input  logic [scc_pkg::MUL_W-1:0]    b_i,
  output logic [scc_pkg::PROD_W-1:0]   prod_o,
  output scc_pkg::scc_unit_status_t    status_o
);
  import scc_pkg::*;

  logic [PROD_W-1:0]    acc_q, acc_d;
  logic [PROD_W-1:0]    mcand_q, mcand_d;
  logic [MUL_W-1:0]     mplier_q, mplier_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      acc_d    = '0;
      mcand_d  = {{(PROD_W-MUL_W){1'b0}}, a_i};
      mplier_d = b_i;
      cnt_d    = MUL_CNT_W'(MUL_W - 1);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = {mcand_q[PROD_W-2:0], 1'b0};
      mplier_d = {1'b0, mplier_q[MUL_W-1:1]};
      cnt_d    = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign prod_o        = acc_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

`default_nettype wire

// ----- sv/scc_div.sv -----
// ----------------------------------------------------------------------------
// Coulomb counter serial divider
// Unsigned restoring divide, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scc_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [scc_pkg::DVD_W-1:0]    dividend_i,
  input  logic [scc_pkg::DSR_W-1:0]    divisor_i,
  output logic [scc_pkg::DVD_W-1:0]    quo_o,
  output logic [scc_pkg::DSR_W-1:0]    rem_o,
  output scc_pkg::scc_unit_status_t    status_o
);
  import scc_pkg::*;

  logic [DSR_W-1:0]     rem_q, rem_d;
  logic [DSR_W-1:0]     dsr_q, dsr_d;
  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [DVD_W-1:0]     quo_q, quo_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DSR_W:0]       trial;
  logic [DSR_W:0]       diff;
  logic                 ge;

  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      dsr_d  = divisor_i;
      dvd_d  = dividend_i;
      quo_d  = '0;
      cnt_d  = DIV_CNT_W'(DVD_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign quo_o         = quo_q;
  assign rem_o         = rem_q;
  assign status_o.busy = busy_q;
  assign status_o.done = done_q;

endmodule

`default_nettype wire

// ----- sv/soc_coulomb_counter.sv -----
// Sequence: an accepted beat runs a multiply, for a sample a summing step, then a divide,
//   an apply step, a second multiply and divide, then publishes; with zero capacity it publishes at once.
// Flow: one beat at a time, the next taken once the result is registered, which waits while
//   the output register holds a beat not yet taken; the work is two multiplies and two divides.
// Reset: asynchronous, active low; the configuration registers return to their defaults and the
//   charge, residue, level and display clear to zero.
// ----------------------------------------------------------------------------
// Coulomb counter state of charge
// Integrates current over time into mAh, applies voltage rules and publishes
// remaining charge, permille level and a slewed display percent.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module soc_coulomb_counter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [scc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [scc_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // current[15:0], elapsed_ms[31:16], min_cell_mv[47:32], charger_on[48],
  // set_percent[56:49], zero fill [63:57]
  input  logic [63:0]                     s_axis_tdata,
  // kind[0]
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // remaining_mah[15:0], level_permille[25:16], shown_percent[32:26],
  // zero fill [39:33]
  output logic [39:0]                     m_axis_tdata
);
  import scc_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL_A = 3'd1;
  localparam logic [2:0] ST_SUM   = 3'd2;
  localparam logic [2:0] ST_DIV_A = 3'd3;
  localparam logic [2:0] ST_APPLY = 3'd4;
  localparam logic [2:0] ST_MUL_P = 3'd5;
  localparam logic [2:0] ST_DIV_P = 3'd6;
  localparam logic [2:0] ST_PUB   = 3'd7;

  logic [2:0]       state_q, state_d;
  logic [CFG_W-1:0] cap_q, full_q, empty_q;

  logic [RES_W-1:0] res_q;
  logic [15:0]      remain_q;
  logic [9:0]       level_q;
  logic [6:0]       disp_q;

  logic             kind_q, cur_neg_q, chg_q, sum_neg_q;
  logic [15:0]      vmin_q;
  logic [6:0]       pct_q;

  logic             out_valid_q;
  logic [15:0]      out_remain_q;
  logic [9:0]       out_level_q;
  logic [6:0]       out_disp_q;

  logic [15:0]      in_current, in_elapsed, in_vmin, abs_cur;
  logic             in_charger, in_fire;
  logic [7:0]       in_pct;
  logic [6:0]       pct_clamp;

  logic             mul_start, div_start, pub_load;
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [PROD_W-1:0] mul_prod;
  logic [DVD_W-1:0] div_dvd, div_quo;
  logic [DSR_W-1:0] div_dsr, div_rem;
  scc_unit_status_t mul_st, div_st;

  logic [SUM_W-1:0] prod_ext, sum_c, sum_abs_w;
  logic [DELTA_W-1:0] delta;
  logic [CHG_W-1:0] charge_w;
  logic [RES_W-1:0] res_new;
  logic [15:0]      charge_clamp, charge_new;

  logic [10:0]      round_sum;
  logic [18:0]      round_prod;
  logic [7:0]       target;
  logic [6:0]       disp_next;

  assign in_current = s_axis_tdata[15:0];
  assign in_elapsed = s_axis_tdata[31:16];
  assign in_vmin    = s_axis_tdata[47:32];
  assign in_charger = s_axis_tdata[48];
  assign in_pct     = s_axis_tdata[56:49];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign abs_cur       = in_current[15] ? (~in_current + 16'd1) : in_current;
  assign pct_clamp     = (in_pct > {1'b0, PCT_MAX}) ? PCT_MAX : in_pct[6:0];

  // operand selection for the shared multiplier
  always_comb begin
    if (state_q == ST_IDLE) begin
      mul_a = (s_axis_tuser == KIND_SET) ? cap_q : abs_cur;
      mul_b = (s_axis_tuser == KIND_SET) ? {{(MUL_W-7){1'b0}}, pct_clamp} : in_elapsed;
    end else begin
      mul_a = charge_new;
      mul_b = PERMILLE;
    end
  end

  assign mul_start = (in_fire && (cap_q != '0)) || (state_q == ST_APPLY);
  assign div_start = (state_q == ST_SUM)
                  || ((state_q == ST_MUL_A) && mul_st.done && (kind_q == KIND_SET))
                  || ((state_q == ST_MUL_P) && mul_st.done);
  assign div_dvd   = (state_q == ST_SUM) ? sum_abs_w[DVD_W-1:0] : mul_prod;
  assign div_dsr   = (state_q == ST_MUL_P) ? {{(DSR_W-CFG_W){1'b0}}, cap_q}
                   : ((kind_q == KIND_SET) ? PCT_DIV : MS_PER_HOUR);

  scc_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .prod_o   (mul_prod),
    .status_o (mul_st)
  );

  scc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .status_o   (div_st)
  );

  // residue plus signed product
  assign prod_ext  = {{(SUM_W-PROD_W){1'b0}}, mul_prod};
  assign sum_c     = {{(SUM_W-RES_W){res_q[RES_W-1]}}, res_q}
                   + (cur_neg_q ? (~prod_ext + 1'b1) : prod_ext);
  assign sum_abs_w = sum_c[SUM_W-1] ? (~sum_c + 1'b1) : sum_c;

  // whole mAh moved out of the residue
  assign delta    = sum_neg_q ? (~div_quo[DELTA_W-1:0] + 1'b1) : div_quo[DELTA_W-1:0];
  assign charge_w = {2'b00, remain_q} + {{(CHG_W-DELTA_W){delta[DELTA_W-1]}}, delta};
  assign res_new  = sum_neg_q ? (~{1'b0, div_rem} + 1'b1) : {1'b0, div_rem};

  always_comb begin
    if (charge_w[CHG_W-1]) begin
      charge_clamp = '0;
    end else if (charge_w[CHG_W-2:0] > {1'b0, cap_q}) begin
      charge_clamp = cap_q;
    end else begin
      charge_clamp = charge_w[15:0];
    end
    if (kind_q == KIND_SET) begin
      charge_new = div_quo[15:0];
    end else if (chg_q && (vmin_q >= full_q)) begin
      charge_new = cap_q;
    end else if (vmin_q <= empty_q) begin
      charge_new = '0;
    end else begin
      charge_new = charge_clamp;
    end
  end

  // rounded percent by reciprocal of ten, then one display step
  assign round_sum  = {1'b0, div_quo[9:0]} + ROUND_BIAS;
  assign round_prod = 19'(round_sum * RECIP_TEN);
  assign target     = round_prod[18:RECIP_SHIFT];

  always_comb begin
    if ({1'b0, disp_q} < target) begin
      disp_next = disp_q + 7'd1;
    end else if ({1'b0, disp_q} > target) begin
      disp_next = disp_q - 7'd1;
    end else begin
      disp_next = disp_q;
    end
  end

  assign pub_load = (state_q == ST_PUB) && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = (cap_q == '0) ? ST_PUB : ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        if (mul_st.done) begin
          state_d = (kind_q == KIND_SET) ? ST_DIV_A : ST_SUM;
        end
      end
      ST_SUM:   state_d = ST_DIV_A;
      ST_DIV_A: begin
        if (div_st.done) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: state_d = ST_MUL_P;
      ST_MUL_P: begin
        if (mul_st.done) begin
          state_d = ST_DIV_P;
        end
      end
      ST_DIV_P: begin
        if (div_st.done) begin
          state_d = ST_PUB;
        end
      end
      ST_PUB: begin
        if (pub_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cap_q       <= CAPACITY_RST;
      full_q      <= FULL_RST;
      empty_q     <= EMPTY_RST;
      res_q       <= '0;
      remain_q    <= '0;
      level_q     <= '0;
      disp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CAPACITY: cap_q   <= cfg_wdata_i;
          CFG_FULL:     full_q  <= cfg_wdata_i;
          CFG_EMPTY:    empty_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == ST_APPLY) begin
        remain_q <= charge_new;
        if (kind_q == KIND_SET) begin
          res_q  <= '0;
          disp_q <= pct_q;
        end else begin
          res_q <= res_new;
        end
      end
      if ((state_q == ST_DIV_P) && div_st.done) begin
        level_q <= div_quo[9:0];
        disp_q  <= disp_next;
      end
      if (pub_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q    <= s_axis_tuser;
      cur_neg_q <= in_current[15];
      vmin_q    <= in_vmin;
      chg_q     <= in_charger;
      pct_q     <= pct_clamp;
    end
    if (state_q == ST_SUM) begin
      sum_neg_q <= sum_c[SUM_W-1];
    end
    if (pub_load) begin
      out_remain_q <= remain_q;
      out_level_q  <= level_q;
      out_disp_q   <= disp_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_disp_q, out_level_q, out_remain_q};

endmodule

`default_nettype wire

// ----- sv/scc_checker.sv -----
// ----------------------------------------------------------------------------
// Coulomb counter port checker
// Watches the stream ports of the top level for ordering and range slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "soc_coulomb_counter_macros.svh"

module scc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  `SCC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `SCC_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `SCC_ASSERT_SAME(a_level_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[25:16] <= 10'd1000)
  `SCC_ASSERT_SAME(a_shown_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[32:26] <= 7'd100)

endmodule

bind soc_coulomb_counter scc_checker u_scc_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// Coulomb counter testbench
// Drives sample and set-percent beats through the stream ports and writes the
// capacity and cell voltage thresholds between phases. It tracks its own copy
// of the residue, charge, level and display state. Every result beat is
// compared, field by field, with the oldest outstanding prediction. A short
// directed part covers the field extremes, both voltage rules, zero and
// lowered capacity and the ignored fields. Random traffic follows under
// several register settings, with bursty stalls on both sides in all but the last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import scc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam longint      MA_MS_PER_MAH = 64'sd3600000;

  typedef struct {
    logic               kind;
    logic signed [15:0] cur_ma;
    logic [15:0]        ms;
    logic [15:0]        cell_mv;
    logic               charger;
    logic [7:0]         pct;
  } soc_item_t;

  typedef struct packed {
    logic [15:0] remaining;
    logic [9:0]  permille;
    logic [6:0]  shown;
  } soc_reading_t;

  typedef int unsigned u32_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  // current[15:0], elapsed_ms[31:16], min_cell_mv[47:32], charger_on[48],
  // set_percent[56:49], zero fill [63:57]
  logic [63:0]       s_axis_tdata;
  // kind[0]
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // remaining_mah[15:0], level_permille[25:16], shown_percent[32:26],
  // zero fill [39:33]
  logic [39:0]       m_axis_tdata;

  logic [15:0]  cfg_capacity;
  logic [15:0]  cfg_full_mv;
  logic [15:0]  cfg_empty_mv;
  longint       soc_residue;
  logic [15:0]  soc_remaining;
  logic [9:0]   soc_level;
  logic [6:0]   soc_display;

  soc_reading_t expected_readings[$];
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  bit           idle_on;

  soc_coulomb_counter uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic void publish_level(input longint charge);
    int unsigned level;
    int unsigned target;
    if (charge < 0) charge = 0;
    if (charge > longint'(cfg_capacity)) charge = longint'(cfg_capacity);
    soc_remaining = charge[15:0];
    level = (u32_t'(soc_remaining) * 1000) / u32_t'(cfg_capacity);
    if (level > 1000) level = 1000;
    soc_level = level[9:0];
    target = (level + 5) / 10;
    if (u32_t'(soc_display) < target) soc_display = soc_display + 7'd1;
    else if (u32_t'(soc_display) > target) soc_display = soc_display - 7'd1;
  endfunction

  function automatic void predict_charge(input soc_item_t it);
    longint      sum;
    longint      delta;
    longint      charge;
    int unsigned pct;
    if (cfg_capacity != 16'd0) begin
      if (it.kind == KIND_SAMPLE) begin
        sum = soc_residue + longint'(it.cur_ma) * longint'(it.ms);
        delta = sum / MA_MS_PER_MAH;
        soc_residue = sum - delta * MA_MS_PER_MAH;
        charge = longint'(soc_remaining) + delta;
        if (it.charger && it.cell_mv >= cfg_full_mv) charge = longint'(cfg_capacity);
        else if (it.cell_mv <= cfg_empty_mv) charge = 0;
        publish_level(charge);
      end else begin
        pct = (it.pct > 8'd100) ? 100 : u32_t'(it.pct);
        soc_residue = 0;
        soc_display = pct[6:0];
        publish_level(longint'((u32_t'(cfg_capacity) * pct) / 100));
      end
    end
    expected_readings.push_back('{soc_remaining, soc_level, soc_display});
  endfunction

  function automatic soc_item_t mk_item(input logic kind, input logic [15:0] cur_ma,
                                        input logic [15:0] ms, input logic [15:0] cell_mv,
                                        input logic charger, input logic [7:0] pct);
    soc_item_t it;
    it.kind = kind;
    it.cur_ma = cur_ma;
    it.ms = ms;
    it.cell_mv = cell_mv;
    it.charger = charger;
    it.pct = pct;
    return it;
  endfunction

  function automatic soc_item_t rand_item();
    soc_item_t   it;
    int unsigned sel;
    it.kind = ($urandom_range(0, 7) == 0) ? KIND_SET : KIND_SAMPLE;
    sel = $urandom_range(0, 3);
    if (sel < 2) it.cur_ma = 16'($urandom_range(0, 4000) - 2000);
    else if (sel == 2) it.cur_ma = 16'($urandom_range(0, 40000) - 20000);
    else it.cur_ma = 16'($urandom());
    it.ms = 16'(($urandom_range(0, 4) < 3) ? $urandom_range(0, 2000)
                                           : $urandom_range(0, 65535));
    if (cfg_full_mv > cfg_empty_mv + 16'd1 && $urandom_range(0, 4) != 0)
      it.cell_mv = 16'($urandom_range(int'(cfg_empty_mv) + 1, int'(cfg_full_mv) - 1));
    else
      it.cell_mv = 16'($urandom_range(0, 65535));
    it.charger = 1'($urandom_range(0, 1));
    it.pct = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 100)
                                           : $urandom_range(0, 255));
    return it;
  endfunction

  task automatic send_item(input soc_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.kind;
    s_axis_tdata  <= {7'd0, it.pct, it.charger, it.cell_mv, it.ms, it.cur_ma};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_charge(it);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [15:0] capacity, input logic [15:0] full_mv,
                            input logic [15:0] empty_mv);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_CAPACITY;
    cfg_wdata_i <= capacity;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_FULL;
    cfg_wdata_i <= full_mv;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_EMPTY;
    cfg_wdata_i <= empty_mv;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_capacity = capacity;
    cfg_full_mv  = full_mv;
    cfg_empty_mv = empty_mv;
    @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    soc_reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_readings.size() == 0) begin
        $display("%0t: result beat with no prediction, actual %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("remaining_mah", 32'(want.remaining), 32'(m_axis_tdata[15:0]));
        check_field("level_permille", 32'(want.permille), 32'(m_axis_tdata[25:16]));
        check_field("shown_percent", 32'(want.shown), 32'(m_axis_tdata[32:26]));
      end
    end
  end

  initial begin
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_set_percent();
    send_item(mk_item(KIND_SET, 16'd0, 16'd0, 16'd3500, 1'b0, 8'd100));
    send_item(mk_item(KIND_SET, 16'd0, 16'd0, 16'd3500, 1'b0, 8'd0));
    send_item(mk_item(KIND_SET, 16'd0, 16'd0, 16'd3500, 1'b0, 8'd101));
    send_item(mk_item(KIND_SET, 16'd0, 16'd0, 16'd3500, 1'b0, 8'd255));
    send_item(mk_item(KIND_SET, 16'h8000, 16'hFFFF, 16'd0, 1'b1, 8'd50));
  endtask

  task automatic test_field_extremes();
    send_item(mk_item(KIND_SAMPLE, 16'h7FFF, 16'hFFFF, 16'd3500, 1'b0, 8'd255));
    send_item(mk_item(KIND_SAMPLE, 16'h8000, 16'hFFFF, 16'd3500, 1'b0, 8'd0));
    send_item(mk_item(KIND_SAMPLE, 16'hFFFF, 16'd1, 16'd3500, 1'b0, 8'd100));
    send_item(mk_item(KIND_SAMPLE, 16'h8000, 16'd0, 16'hFFFF, 1'b0, 8'd7));
    send_item(mk_item(KIND_SAMPLE, 16'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0, 8'd0));
    send_item(mk_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd0, 1'b1, 8'd0));
  endtask

  task automatic test_voltage_rules();
    send_item(mk_item(KIND_SET, 16'd0, 16'd0, 16'd0, 1'b0, 8'd50));
    send_item(mk_item(KIND_SAMPLE, 16'd100, 16'd100, 16'd4150, 1'b0, 8'd0));
    send_item(mk_item(KIND_SAMPLE, 16'd100, 16'd100, 16'd4150, 1'b1, 8'd0));
    send_item(mk_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd3000, 1'b1, 8'd0));
    send_item(mk_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd3001, 1'b0, 8'd0));
  endtask

  task automatic test_capacity_lowered();
    drain();
    set_config(16'hFFFF, 16'hFFFF, 16'd0);
    send_item(mk_item(KIND_SET, 16'd0, 16'd0, 16'd2000, 1'b0, 8'd100));
    send_item(mk_item(KIND_SAMPLE, 16'd0, 16'd0, 16'hFFFF, 1'b1, 8'd0));
    drain();
    set_config(16'd1000, 16'hFFFF, 16'd0);
    send_item(mk_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd2000, 1'b0, 8'd0));
  endtask

  task automatic test_threshold_extremes();
    drain();
    set_config(16'd500, 16'd0, 16'hFFFF);
    send_item(mk_item(KIND_SAMPLE, 16'd0, 16'd0, 16'd0, 1'b1, 8'd0));
    send_item(mk_item(KIND_SAMPLE, 16'd0, 16'd0, 16'hFFFF, 1'b0, 8'd0));
  endtask

  task automatic test_zero_capacity();
    drain();
    set_config(16'd0, 16'd4150, 16'd3000);
    send_item(mk_item(KIND_SET, 16'd0, 16'd0, 16'd0, 1'b0, 8'd80));
    send_item(mk_item(KIND_SAMPLE, 16'h7FFF, 16'hFFFF, 16'd3500, 1'b1, 8'd0));
  endtask

  task automatic test_random_traffic(input int unsigned count, input bit idle,
                                     input logic [15:0] capacity,
                                     input logic [15:0] full_mv,
                                     input logic [15:0] empty_mv);
    drain();
    set_config(capacity, full_mv, empty_mv);
    idle_on = idle;
    repeat (count) send_item(rand_item());
  endtask

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_CAPACITY;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= KIND_SAMPLE;
    cfg_capacity  = CAPACITY_RST;
    cfg_full_mv   = FULL_RST;
    cfg_empty_mv  = EMPTY_RST;
    soc_residue   = 0;
    soc_remaining = '0;
    soc_level     = '0;
    soc_display   = '0;
    idle_on       = 1'b1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_set_percent();
    test_field_extremes();
    test_voltage_rules();
    test_capacity_lowered();
    test_threshold_extremes();
    test_zero_capacity();
    test_random_traffic(300, 1'b1, 16'd1000, 16'd4150, 16'd3000);
    test_random_traffic(250, 1'b1, 16'hFFFF, 16'hFFFF, 16'd0);
    test_random_traffic(100, 1'b1, 16'd1, 16'($urandom_range(3900, 4300)),
                        16'($urandom_range(2500, 3300)));
    test_random_traffic(150, 1'b1, 16'($urandom_range(1, 5000)),
                        16'($urandom_range(3900, 4300)), 16'($urandom_range(2500, 3300)));
    test_random_traffic(200, 1'b0, 16'($urandom_range(1, 65535)),
                        16'($urandom_range(3900, 4300)), 16'($urandom_range(2500, 3300)));

    drain();
    repeat (120) @(posedge clk_i);
    if (expected_readings.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time, expected_readings.size());
    end
    if (fail_count == 0 && expected_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- soc_coulomb_counter.f -----
+incdir+sv
sv/scc_pkg.sv
sv/scc_mul.sv
sv/scc_div.sv
sv/soc_coulomb_counter.sv
sv/scc_checker.sv
tb/sv/tb_top.sv
